// ===== rtl/srmf_pkg.sv =====
// Shared types, constants and a helper function for the scan range median filter.
// Used by srmf_cell and scan_range_median_filter; depends on nothing else.
package srmf_pkg;

   localparam int MAX_WINDOW = 15;
   localparam int RADIUS_MAX = (MAX_WINDOW - 1) / 2;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int AGE_W      = (RADIUS_MAX > 1) ? $clog2(RADIUS_MAX + 1) : 1;
   localparam int SEEN_W     = 5;
   localparam int SEEN_MAX   = 31;
   localparam int VALUE_W    = 16;
   localparam int CLASS_W    = 2;
   localparam int WINDOW_W   = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CLASS_W-1:0] CLASS_FINITE = 2'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 2'd0,
      CSR_WINDOW = 2'd1,
      CSR_MIN    = 2'd2,
      CSR_MAX    = 2'd3
   } csr_index_type;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [MAX_WINDOW-1:0] mask_type;

   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      value_type          value;
   } sample_type;

   typedef sample_type [MAX_WINDOW-1:0] window_type;

   typedef struct packed {
      logic             shift;
      logic             load;
      logic [IDX_W-1:0] hi;
      value_type        range_lo;
      value_type        range_hi;
      logic [CNT_W-1:0] median_rank;
   } cell_ctrl_type;

   function automatic logic [CNT_W-1:0] popcount(input mask_type bits);
      logic [CNT_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         sum = sum + CNT_W'(bits[i]);
      end
      return sum;
   endfunction

endpackage

// ===== rtl/srmf_cell.sv =====
// One cell of the sample window: holds one stored sample, ranks it against the window
// and offers it as the median. Depends on srmf_pkg.
module srmf_cell (
   input  logic                          clock,
   input  logic [srmf_pkg::IDX_W-1:0]    cell_index,
   input  srmf_pkg::cell_ctrl_type       ctrl,
   input  srmf_pkg::sample_type          left_sample,
   input  srmf_pkg::window_type          view,
   input  srmf_pkg::mask_type            view_mask,
   output srmf_pkg::sample_type          entry_out,
   output srmf_pkg::sample_type          own_view,
   output logic                          view_ok,
   output logic                          rank_valid,
   output srmf_pkg::value_type           median_value
);

   srmf_pkg::sample_type     entry_ff;
   srmf_pkg::value_type      value_ff;
   logic                     valid_ff;
   srmf_pkg::mask_type       before_ff;
   srmf_pkg::mask_type       before_in;
   logic [srmf_pkg::CNT_W-1:0] rank;

   assign entry_out = entry_ff;
   assign own_view  = ctrl.shift ? left_sample : entry_ff;

   assign view_ok = (own_view.cls == srmf_pkg::CLASS_FINITE) &&
                    (own_view.value >= ctrl.range_lo) &&
                    ((ctrl.range_hi == '0) || (own_view.value <= ctrl.range_hi)) &&
                    (cell_index <= ctrl.hi);

   // Equal values are ordered by position so that every valid sample gets a unique rank.
   always_comb begin
      for (int j = 0; j < srmf_pkg::MAX_WINDOW; j++) begin
         before_in[j] = view_mask[j] &&
                        ((view[j].value < own_view.value) ||
                         ((view[j].value == own_view.value) &&
                          (srmf_pkg::IDX_W'(j) < cell_index)));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         entry_ff <= left_sample;
      end
      if (ctrl.load) begin
         value_ff  <= own_view.value;
         valid_ff  <= view_ok;
         before_ff <= before_in;
      end
   end

   assign rank         = srmf_pkg::popcount(before_ff);
   assign rank_valid   = valid_ff;
   assign median_value = (valid_ff && (rank == ctrl.median_rank)) ? value_ff : '0;

endmodule

// ===== rtl/scan_range_median_filter.sv =====
// Top level of the scan range median filter: configuration registers, scan sequencing,
// the row of srmf_cell window cells and the output register. Depends on srmf_pkg.
//
// The filter takes one range word per cycle when not stalled and returns each sample
// replaced by the median of the valid samples in a window of 2r+1 samples around it,
// where r is half the configured window size (zero when filtering is off). Results
// trail the input by r samples; a word passes through the cell and stage-1 registers
// and then the output register after the sample that completes its window is taken.
// The end-of-scan word produces up to r+1 results; the input is stalled while the
// sequencer drains the pending samples, at most r, one per cycle unless the output stalls.
// Each result is ranked in a single pass through the cell row, so the rate is one
// result per cycle whenever the output side is not stalled.
module scan_range_median_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [srmf_pkg::VALUE_W-1:0]      req_range_value,
   input  logic [srmf_pkg::CLASS_W-1:0]      req_range_class,
   input  logic                              req_end_of_scan,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [srmf_pkg::VALUE_W-1:0]      rsp_filtered_value,
   output logic [srmf_pkg::CLASS_W-1:0]      rsp_filtered_class,
   output logic                              rsp_scan_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srmf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srmf_pkg::VALUE_W-1:0]      csr_data
);

   localparam int IDX_W  = srmf_pkg::IDX_W;
   localparam int CNT_W  = srmf_pkg::CNT_W;
   localparam int AGE_W  = srmf_pkg::AGE_W;
   localparam int SEEN_W = srmf_pkg::SEEN_W;

   logic                          enable_ff, enable_in;
   logic [srmf_pkg::WINDOW_W-1:0] window_ff, window_in;
   srmf_pkg::value_type           min_ff, min_in;
   srmf_pkg::value_type           max_ff, max_in;

   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic                flush_ff, flush_in;
   logic [AGE_W-1:0]    pend_ff, pend_in;
   logic [CNT_W-1:0]    avail_ff, avail_in;

   logic                 s1_valid_ff, s1_valid_in;
   srmf_pkg::sample_type s1_center_ff, s1_center_in;
   logic                 s1_last_ff, s1_last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   srmf_pkg::sample_type rsp_word_ff, rsp_word_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]  half_w;
   logic [AGE_W-1:0]  radius;
   logic [CNT_W-1:0]  w_len;
   logic [SEEN_W-1:0] seen_inc;
   logic [CNT_W-1:0]  avail_new;
   logic              s2_take, s1_take, accept, flush_step, main_job;
   logic              job_valid, job_last;
   logic [AGE_W-1:0]  job_age;
   logic [IDX_W-1:0]  job_hi, hi_span, hi_cap;
   logic [AGE_W-1:0]  flush_age;

   srmf_pkg::cell_ctrl_type ctrl;
   srmf_pkg::sample_type    new_sample;
   srmf_pkg::window_type    entries, view;
   srmf_pkg::mask_type      view_mask, rank_mask;
   srmf_pkg::value_type     cell_median [srmf_pkg::MAX_WINDOW];
   srmf_pkg::value_type     median;
   logic [CNT_W-1:0]        valid_count;

   assign csr_ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      window_in = window_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      if (csr_valid) begin
         unique case (srmf_pkg::csr_index_type'(csr_index))
            srmf_pkg::CSR_ENABLE: enable_in = csr_data[0];
            srmf_pkg::CSR_WINDOW: window_in = csr_data[srmf_pkg::WINDOW_W-1:0];
            srmf_pkg::CSR_MIN:    min_in    = csr_data;
            srmf_pkg::CSR_MAX:    max_in    = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      half_w = CNT_W'(window_ff >> 1);
      if (!enable_ff) begin
         radius = '0;
      end else if (half_w > CNT_W'(srmf_pkg::RADIUS_MAX)) begin
         radius = AGE_W'(srmf_pkg::RADIUS_MAX);
      end else begin
         radius = AGE_W'(half_w);
      end
      w_len = CNT_W'({radius, 1'b1});
   end

   assign seen_inc  = (seen_ff == SEEN_W'(srmf_pkg::SEEN_MAX)) ? seen_ff : seen_ff + 1'b1;
   assign avail_new = (seen_inc < SEEN_W'(w_len)) ? CNT_W'(seen_inc) : w_len;
   assign main_job  = seen_inc > SEEN_W'(radius);

   assign s2_take    = !rsp_valid_ff || !rsp_stall;
   assign s1_take    = !s1_valid_ff || s2_take;
   assign req_stall  = flush_ff || !s1_take;
   assign accept     = req_valid && !req_stall;
   assign flush_step = flush_ff && s1_take;
   assign flush_age  = pend_ff - 1'b1;

   always_comb begin
      job_valid = 1'b0;
      job_age   = radius;
      job_last  = 1'b0;
      hi_span   = IDX_W'({radius, 1'b0});
      hi_cap    = IDX_W'(avail_new - 1'b1);
      if (accept) begin
         job_valid = main_job;
         job_last  = req_end_of_scan && (radius == '0);
      end else if (flush_step) begin
         job_valid = 1'b1;
         job_age   = flush_age;
         job_last  = (flush_age == '0);
         hi_span   = IDX_W'(flush_age) + IDX_W'(radius);
         hi_cap    = IDX_W'(avail_ff - 1'b1);
      end
      job_hi = (hi_span > hi_cap) ? hi_cap : hi_span;
   end

   always_comb begin
      seen_in  = seen_ff;
      flush_in = flush_ff;
      pend_in  = pend_ff;
      avail_in = avail_ff;
      if (accept) begin
         seen_in = req_end_of_scan ? '0 : seen_inc;
         if (req_end_of_scan) begin
            pend_in  = main_job ? radius : AGE_W'(seen_inc);
            flush_in = (pend_in != '0);
            avail_in = avail_new;
         end
      end else if (flush_step) begin
         pend_in  = flush_age;
         flush_in = (pend_ff != AGE_W'(1));
      end
   end

   assign new_sample.cls   = req_range_class;
   assign new_sample.value = req_range_value;

   assign ctrl.shift       = accept;
   assign ctrl.load        = job_valid;
   assign ctrl.hi          = job_hi;
   assign ctrl.range_lo    = min_ff;
   assign ctrl.range_hi    = max_ff;
   assign ctrl.median_rank = valid_count >> 1;

   for (genvar k = 0; k < srmf_pkg::MAX_WINDOW; k++) begin : g_cell
      srmf_cell u_cell (
         .clock        (clock),
         .cell_index   (IDX_W'(k)),
         .ctrl         (ctrl),
         .left_sample  ((k == 0) ? new_sample : entries[(k == 0) ? 0 : k - 1]),
         .view         (view),
         .view_mask    (view_mask),
         .entry_out    (entries[k]),
         .own_view     (view[k]),
         .view_ok      (view_mask[k]),
         .rank_valid   (rank_mask[k]),
         .median_value (cell_median[k])
      );
   end

   assign valid_count = srmf_pkg::popcount(rank_mask);

   always_comb begin
      median = '0;
      for (int k = 0; k < srmf_pkg::MAX_WINDOW; k++) begin
         median = median | cell_median[k];
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_center_in = s1_center_ff;
      s1_last_in   = s1_last_ff;
      if (s1_take) begin
         s1_valid_in = job_valid;
      end
      if (job_valid) begin
         s1_center_in = view[IDX_W'(job_age)];
         s1_last_in   = job_last;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (s2_take) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_last_in = s1_last_ff;
            if (valid_count == '0) begin
               rsp_word_in = s1_center_ff;
            end else begin
               rsp_word_in.cls   = srmf_pkg::CLASS_FINITE;
               rsp_word_in.value = median;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         window_ff    <= srmf_pkg::WINDOW_W'(5);
         min_ff       <= '0;
         max_ff       <= '0;
         seen_ff      <= '0;
         flush_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         window_ff    <= window_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         seen_ff      <= seen_in;
         flush_ff     <= flush_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      avail_ff     <= avail_in;
      s1_center_ff <= s1_center_in;
      s1_last_ff   <= s1_last_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_word_ff.value;
   assign rsp_filtered_class = rsp_word_ff.cls;
   assign rsp_scan_last      = rsp_last_ff;

endmodule

// ===== tb/tb_scan_range_median_filter.sv =====
// Self-checking testbench for scan_range_median_filter: random idle gaps on the request
// channel, random response stalls, register writes between phases and a built-in predictor
// of the windowed median. Depends on srmf_pkg and the scan_range_median_filter RTL.
module tb_scan_range_median_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [srmf_pkg::CLASS_W-1:0] CLASS_NAN  = 2'd1;
   localparam logic [srmf_pkg::CLASS_W-1:0] CLASS_INF  = 2'd2;
   localparam logic [srmf_pkg::CLASS_W-1:0] CLASS_RSVD = 2'd3;
   localparam int SETTLE_CYCLES = 24;
   localparam int IDLE_PCT      = 36;
   localparam int NUM_PHASES    = 10;
   localparam int PHASE_ITEMS   = 20;

   typedef struct packed {
      srmf_pkg::value_type          value;
      logic [srmf_pkg::CLASS_W-1:0] cls;
      logic                         eos;
   } range_item_type;

   typedef struct packed {
      srmf_pkg::value_type          value;
      logic [srmf_pkg::CLASS_W-1:0] cls;
      logic                         last;
   } filtered_word_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [srmf_pkg::VALUE_W-1:0]   req_range_value = '0;
   logic [srmf_pkg::CLASS_W-1:0]   req_range_class = '0;
   logic                           req_end_of_scan = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [srmf_pkg::VALUE_W-1:0]   rsp_filtered_value;
   logic [srmf_pkg::CLASS_W-1:0]   rsp_filtered_class;
   logic                           rsp_scan_last;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   srmf_pkg::csr_index_type        csr_index = srmf_pkg::CSR_ENABLE;
   logic [srmf_pkg::VALUE_W-1:0]   csr_data = '0;

   range_item_type                 pending_samples[$];
   filtered_word_type              filtered_due[$];
   srmf_pkg::sample_type           recent[srmf_pkg::MAX_WINDOW];
   int                             seen;
   logic                           cfg_enable;
   logic [srmf_pkg::WINDOW_W-1:0]  cfg_window;
   srmf_pkg::value_type            cfg_min;
   srmf_pkg::value_type            cfg_max;
   int                             idle_pct = IDLE_PCT;
   int                             mismatches = 0;
   int                             items_sent = 0;
   int                             words_checked = 0;
   int                             scans_closed = 0;
   int                             csr_writes = 0;

   scan_range_median_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_range_value    (req_range_value),
      .req_range_class    (req_range_class),
      .req_end_of_scan    (req_end_of_scan),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_filtered_class (rsp_filtered_class),
      .rsp_scan_last      (rsp_scan_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   function automatic int window_radius();
      int wsz;
      int cap;
      wsz = cfg_window;
      cap = (srmf_pkg::MAX_WINDOW % 2 == 0) ? srmf_pkg::MAX_WINDOW - 1 : srmf_pkg::MAX_WINDOW;
      if (!cfg_enable) return 0;
      if (wsz < 1) wsz = 1;
      if (wsz % 2 == 0) wsz = wsz + 1;
      if (wsz > cap) wsz = cap;
      return wsz / 2;
   endfunction

   function automatic bit in_range(srmf_pkg::sample_type s);
      if (s.cls != srmf_pkg::CLASS_FINITE) return 1'b0;
      if (s.value < cfg_min) return 1'b0;
      if (cfg_max != 0 && s.value > cfg_max) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void queue_median(int age, int hi, logic last);
      srmf_pkg::value_type  sorted[srmf_pkg::MAX_WINDOW];
      int                   n;
      int                   j;
      srmf_pkg::sample_type center;
      filtered_word_type    word;
      n = 0;
      center = recent[age % srmf_pkg::MAX_WINDOW];
      for (int k = 0; k <= hi && k < srmf_pkg::MAX_WINDOW; k++) begin
         if (in_range(recent[k])) begin
            j = n;
            while (j > 0 && sorted[j-1] > recent[k].value) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = recent[k].value;
            n++;
         end
      end
      if (n > 0) begin
         word.value = sorted[n/2];
         word.cls   = srmf_pkg::CLASS_FINITE;
      end else begin
         word.value = center.value;
         word.cls   = center.cls;
      end
      word.last = last;
      filtered_due.insert(filtered_due.size(), word);
   endfunction

   function automatic void filter_sample(srmf_pkg::value_type v,
                                         logic [srmf_pkg::CLASS_W-1:0] c, logic eos);
      int r;
      int w;
      int avail;
      int hi;
      int p;
      r = window_radius();
      w = 2 * r + 1;
      for (int k = srmf_pkg::MAX_WINDOW - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0].value = v;
      recent[0].cls   = c;
      if (seen < srmf_pkg::SEEN_MAX) seen++;
      avail = (seen < w) ? seen : w;
      if (seen > r) begin
         hi = 2 * r;
         if (hi > avail - 1) hi = avail - 1;
         queue_median(r, hi, eos && r == 0);
      end
      if (eos) begin
         p = (seen > r) ? r : seen;
         while (p > 0) begin
            hi = p - 1 + r;
            if (hi > avail - 1) hi = avail - 1;
            queue_median(p - 1, hi, p == 1);
            p--;
         end
         seen = 0;
         scans_closed++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_sample(req_range_value, req_range_class, req_end_of_scan);
            void'(pending_samples.pop_front());
            items_sent++;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid       <= 1'b1;
            req_range_value <= pending_samples[0].value;
            req_range_class <= pending_samples[0].cls;
            req_end_of_scan <= pending_samples[0].eos;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      filtered_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (filtered_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, got value %0d class %0d last %0d",
                        $time, rsp_filtered_value, rsp_filtered_class, rsp_scan_last);
            end else begin
               want = filtered_due.pop_front();
               if (rsp_filtered_value !== want.value) begin
                  mismatches++;
                  $display("%0t: filtered_value expected %0d, got %0d",
                           $time, want.value, rsp_filtered_value);
               end
               if (rsp_filtered_class !== want.cls) begin
                  mismatches++;
                  $display("%0t: filtered_class expected %0d, got %0d",
                           $time, want.cls, rsp_filtered_class);
               end
               if (rsp_scan_last !== want.last) begin
                  mismatches++;
                  $display("%0t: scan_last expected %0d, got %0d",
                           $time, want.last, rsp_scan_last);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   task automatic write_reg(input srmf_pkg::csr_index_type idx,
                            input logic [srmf_pkg::VALUE_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         srmf_pkg::CSR_ENABLE: cfg_enable = data[0];
         srmf_pkg::CSR_WINDOW: cfg_window = data[srmf_pkg::WINDOW_W-1:0];
         srmf_pkg::CSR_MIN:    cfg_min    = data;
         srmf_pkg::CSR_MAX:    cfg_max    = data;
         default:              cfg_enable = cfg_enable;
      endcase
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic write_config(input logic en, input logic [srmf_pkg::WINDOW_W-1:0] win,
                               input srmf_pkg::value_type mn, input srmf_pkg::value_type mx);
      logic [srmf_pkg::VALUE_W-1:0] d;
      d = srmf_pkg::VALUE_W'($urandom);
      d[0] = en;
      write_reg(srmf_pkg::CSR_ENABLE, d);
      d = srmf_pkg::VALUE_W'($urandom);
      d[srmf_pkg::WINDOW_W-1:0] = win;
      write_reg(srmf_pkg::CSR_WINDOW, d);
      write_reg(srmf_pkg::CSR_MIN, mn);
      write_reg(srmf_pkg::CSR_MAX, mx);
   endtask

   task automatic settle();
      while (pending_samples.size() != 0 || filtered_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_sample(input srmf_pkg::value_type v,
                             input logic [srmf_pkg::CLASS_W-1:0] c, input logic eos);
      range_item_type item;
      item.value = v;
      item.cls   = c;
      item.eos   = eos;
      pending_samples.insert(pending_samples.size(), item);
   endtask

   function automatic srmf_pkg::value_type pick_value();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return srmf_pkg::VALUE_W'($urandom_range(65535));
         default: return srmf_pkg::VALUE_W'($urandom_range(3000));
      endcase
   endfunction

   function automatic logic [srmf_pkg::CLASS_W-1:0] pick_class();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return srmf_pkg::CLASS_FINITE;
      if (roll < 80) return CLASS_NAN;
      if (roll < 90) return CLASS_INF;
      return CLASS_RSVD;
   endfunction

   initial begin
      logic                          en;
      logic [srmf_pkg::WINDOW_W-1:0] win;
      srmf_pkg::value_type           mn;
      srmf_pkg::value_type           mx;
      int                            count;
      int                            len;
      logic                          close;
      for (int k = 0; k < srmf_pkg::MAX_WINDOW; k++) recent[k] = '0;
      seen       = 0;
      cfg_enable = 1'b1;
      cfg_window = 4'd5;
      cfg_min    = '0;
      cfg_max    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_sample(16'd0, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'hFFFF, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'd7, CLASS_NAN, 1'b0);
      add_sample(16'd9, CLASS_INF, 1'b0);
      add_sample(16'hFFFF, CLASS_RSVD, 1'b0);
      add_sample(16'd1200, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'd300, srmf_pkg::CLASS_FINITE, 1'b1);
      settle();
      write_reg(srmf_pkg::CSR_MIN, 16'd1000);
      write_reg(srmf_pkg::CSR_MAX, 16'd2000);
      add_sample(16'd500, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'hFFFF, CLASS_NAN, 1'b0);
      add_sample(16'd3, CLASS_RSVD, 1'b1);
      settle();
      write_reg(srmf_pkg::CSR_WINDOW, 16'd15);
      add_sample(16'd1500, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'd42, CLASS_INF, 1'b1);
      settle();
      write_reg(srmf_pkg::CSR_WINDOW, 16'd7);
      write_reg(srmf_pkg::CSR_MIN, 16'd0);
      write_reg(srmf_pkg::CSR_MAX, 16'hFFFF);
      add_sample(16'd10, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'd20, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'hFFFF, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'd5, CLASS_NAN, 1'b0);
      settle();
      write_reg(srmf_pkg::CSR_WINDOW, 16'd4);
      add_sample(16'd30, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'd1, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'd2, srmf_pkg::CLASS_FINITE, 1'b1);
      settle();
      write_reg(srmf_pkg::CSR_ENABLE, 16'd0);
      add_sample(16'd77, CLASS_RSVD, 1'b0);
      add_sample(16'd0, CLASS_NAN, 1'b0);
      add_sample(16'd123, srmf_pkg::CLASS_FINITE, 1'b1);
      settle();
      write_reg(srmf_pkg::CSR_ENABLE, 16'd1);
      write_reg(srmf_pkg::CSR_WINDOW, 16'd0);
      add_sample(16'd5, srmf_pkg::CLASS_FINITE, 1'b0);
      add_sample(16'd6, CLASS_RSVD, 1'b1);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         en  = (ph == 4) ? 1'b0 : ($urandom_range(9) != 0);
         win = (ph == 0) ? 4'd15 : (ph == 1) ? 4'd1 : (ph == 6) ? 4'd0
                                 : srmf_pkg::WINDOW_W'($urandom_range(15));
         mn  = ($urandom_range(99) < 30) ? '0 : srmf_pkg::VALUE_W'($urandom_range(2500));
         case ($urandom_range(3))
            0:       mx = '0;
            1:       mx = '1;
            2:       mx = srmf_pkg::VALUE_W'(mn + $urandom_range(2000));
            default: mx = srmf_pkg::VALUE_W'($urandom_range(3000));
         endcase
         if (ph == 5) begin
            mn = '1;
            mx = '0;
         end
         write_config(en, win, mn, mx);
         idle_pct = (ph == 2) ? 0 : IDLE_PCT;
         count = 0;
         while (count < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 12);
            close = 1'b1;
            if (count + len >= PHASE_ITEMS && ph != NUM_PHASES - 1)
               close = ($urandom_range(3) != 0);
            for (int i = 0; i < len; i++)
               add_sample(pick_value(), pick_class(), close && i == len - 1);
            count += len;
         end
      end

      settle();
      $display("Sent %0d samples in %0d closed scans with %0d register writes.",
               items_sent, scans_closed, csr_writes);
      $display("Checked %0d filtered words against the predicted medians.", words_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out waiting for filtered words.");
      $display("Mismatches found");
      $finish;
   end

endmodule
